FILE: rtl/core/lsp_pkg.sv
// Shared constants, codes and the token type of the lottery scheduler pick block.
`default_nettype none
package lsp_pkg;

	localparam int NUM_SLOTS   = 64;
	localparam int TICKET_BITS = 16;

	localparam int IDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int SUM_W    = TICKET_BITS + IDX_W;
	localparam int RND_W    = 32;
	localparam int CNT_W    = $clog2(RND_W + 1);
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 6;
	localparam int TOTAL_W  = 22;
	localparam int TKIN_W   = 16;

	localparam logic [STATUS_W-1:0] ST_UNUSED   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RUNNABLE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RUNNING  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BLOCKED  = 2'd3;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_DRAW  = 1'b1;

	// token walking the cell chain: sum pass (sel = 0) or selection pass (sel = 1)
	typedef struct packed {
		logic             vld;
		logic             sel;
		logic [SUM_W-1:0] acc;
		logic             found;
		logic [IDX_W-1:0] win;
	} lsp_tok_t;

endpackage
`default_nettype wire

FILE: rtl/core/lsp_cell.sv
// One slot cell: holds a slot's status and tickets and advances the token by one slot.
`default_nettype none
module lsp_cell (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [lsp_pkg::STATUS_W-1:0]    wr_status,
	input  wire logic [lsp_pkg::TICKET_BITS-1:0] wr_tickets,
	input  wire logic [lsp_pkg::IDX_W-1:0]       my_index,
	input  wire logic [lsp_pkg::SUM_W-1:0]       draw,
	input  wire lsp_pkg::lsp_tok_t               tok_in,
	output lsp_pkg::lsp_tok_t                    tok_out
);
	import lsp_pkg::*;

	logic [STATUS_W-1:0]    status_q;
	logic [TICKET_BITS-1:0] tickets_q;
	lsp_tok_t               tok_q;
	lsp_tok_t               tok_nxt;
	logic [SUM_W-1:0]       span_end;
	logic                   live;
	logic                   hit;

	assign live     = (status_q != ST_UNUSED);
	assign span_end = tok_in.acc + SUM_W'(tickets_q);

	always_comb begin
		tok_nxt = tok_in;
		hit     = 1'b0;
		if (tok_in.vld && live) begin
			if (!tok_in.sel) begin
				tok_nxt.acc = span_end;
			end else if (!tok_in.found) begin
				if (status_q == ST_RUNNABLE && draw >= tok_in.acc && draw < span_end) begin
					tok_nxt.found = 1'b1;
					tok_nxt.win   = my_index;
					hit           = 1'b1;
				end else begin
					tok_nxt.acc = span_end;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= ST_UNUSED;
			tickets_q <= '0;
			tok_q     <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (wr_en) begin
				status_q  <= wr_status;
				tickets_q <= wr_tickets;
			end else if (hit) begin
				status_q <= ST_RUNNING;
			end
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

FILE: rtl/core/lsp_mod.sv
// Bit-serial remainder unit: random value modulo the ticket total, one bit a cycle.
`default_nettype none
module lsp_mod (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      go,
	input  wire logic [lsp_pkg::RND_W-1:0] dividend,
	input  wire logic [lsp_pkg::SUM_W-1:0] divisor,
	output logic                           rdy,
	output logic [lsp_pkg::SUM_W-1:0]      rem
);
	import lsp_pkg::*;

	logic             run_q;
	logic             rdy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RND_W-1:0] dvd_q;
	logic [SUM_W-1:0] dvs_q;
	logic [SUM_W-1:0] rem_q;
	logic [SUM_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, dvd_q[RND_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			rdy_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			rdy_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(RND_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
					rdy_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= dvd_q << 1;
			if (fits) begin
				rem_q <= SUM_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[SUM_W-1:0];
			end
		end
	end

	assign rdy = rdy_q;
	assign rem = rem_q;

endmodule
`default_nettype wire

FILE: rtl/core/lottery_scheduler_pick.sv
// Top level of the lottery scheduler pick block: request decode, cell chain and sequencing.
//
// Usage: a request word is taken at a rising edge with start high and busy low.
// req_type write stores new_status and new_tickets into slot slot_index (ignored when
// the index is beyond the table); req_type draw picks a winner with random_value.
// Every request gives exactly one result word, shown for one cycle with done high:
// winner_found, winner_index and ticket_total (all zero for a write).
// Latency: a write answers in the cycle after acceptance and busy stays low.
// A draw walks a token down the chain of NUM_SLOTS cells to sum the tickets,
// reduces random_value modulo the sum in a bit-serial unit, then walks the chain
// again to find the holder of the drawn ticket. Busy is high until its result word.
// A zero ticket sum skips the modulo step and the second walk. The winning cell marks itself running.
// Reset clears every slot to unused with zero tickets and leaves the block idle.
// The receiver cannot stall: each result word is valid only in its done cycle.
`default_nettype none
module lottery_scheduler_pick (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            req_type,
	input  wire logic [5:0]                      slot_index,
	input  wire logic [lsp_pkg::STATUS_W-1:0]    new_status,
	input  wire logic [lsp_pkg::TKIN_W-1:0]      new_tickets,
	input  wire logic [lsp_pkg::RND_W-1:0]       random_value,
	output logic                                 done,
	output logic                                 winner_found,
	output logic [lsp_pkg::INDEX_W-1:0]          winner_index,
	output logic [lsp_pkg::TOTAL_W-1:0]          ticket_total
);
	import lsp_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SUM  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_SEL  = 2'd3;

	logic [1:0]             state_q;
	lsp_tok_t               launch_q;
	logic                   done_q;
	logic                   found_q;
	logic [INDEX_W-1:0]     win_q;
	logic [TOTAL_W-1:0]     total_out_q;
	logic [RND_W-1:0]       rnd_q;
	logic [SUM_W-1:0]       total_q;
	logic [SUM_W-1:0]       draw_q;
	logic                   accept;
	logic                   mod_go;
	logic                   mod_rdy;
	logic [SUM_W-1:0]       mod_rem;
	logic [TICKET_BITS-1:0] wr_tickets;
	logic [NUM_SLOTS-1:0]   wr_en;
	logic [NUM_SLOTS:0]     tok_vld;
	lsp_tok_t               chain [NUM_SLOTS+1];
	lsp_tok_t               tail;

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign wr_tickets = TICKET_BITS'(new_tickets);
	assign chain[0]   = launch_q;
	assign tail       = chain[NUM_SLOTS];
	assign mod_go     = (state_q == S_SUM) && tail.vld && (tail.acc != '0);

	genvar g;
	generate
		for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
			assign wr_en[g] = accept && (req_type == REQ_WRITE) &&
				(32'(slot_index) == 32'(g));

			lsp_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.wr_en      (wr_en[g]),
				.wr_status  (new_status),
				.wr_tickets (wr_tickets),
				.my_index   (IDX_W'(g)),
				.draw       (draw_q),
				.tok_in     (chain[g]),
				.tok_out    (chain[g+1])
			);
		end
		for (g = 0; g <= NUM_SLOTS; g++) begin : g_vld
			assign tok_vld[g] = chain[g].vld;
		end
	endgenerate

	lsp_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (mod_go),
		.dividend (rnd_q),
		.divisor  (tail.acc),
		.rdy      (mod_rdy),
		.rem      (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			launch_q    <= '0;
			done_q      <= 1'b0;
			found_q     <= 1'b0;
			win_q       <= '0;
			total_out_q <= '0;
		end else begin
			launch_q <= '0;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_type == REQ_DRAW) begin
							launch_q <= '{vld: 1'b1, sel: 1'b0, default: '0};
							state_q  <= S_SUM;
						end else begin
							done_q      <= 1'b1;
							win_q       <= '0;
							total_out_q <= '0;
						end
					end
				end
				S_SUM: begin
					if (tail.vld) begin
						if (tail.acc == '0) begin
							done_q      <= 1'b1;
							win_q       <= '0;
							total_out_q <= '0;
							state_q     <= S_IDLE;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (mod_rdy) begin
						launch_q <= '{vld: 1'b1, sel: 1'b1, default: '0};
						state_q  <= S_SEL;
					end
				end
				S_SEL: begin
					if (tail.vld) begin
						done_q      <= 1'b1;
						found_q     <= tail.found;
						win_q       <= tail.found ? INDEX_W'(tail.win) : '0;
						total_out_q <= TOTAL_W'(total_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rnd_q <= random_value;
		end
		if (state_q == S_SUM && tail.vld) begin
			total_q <= tail.acc;
		end
		if (mod_rdy) begin
			draw_q <= mod_rem;
		end
	end

	assign done         = done_q;
	assign winner_found = found_q;
	assign winner_index = win_q;
	assign ticket_total = total_out_q;

	a_write_word: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == REQ_WRITE) |=>
			(done && !winner_found && winner_index == '0 && ticket_total == '0))
		else $error("write request did not give an all-zero result word");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while still busy");

	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		winner_found |-> done)
		else $error("winner flagged outside a result word");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one token in the cell chain");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (total_q != '0))
		else $error("modulo started with a zero ticket total");

endmodule
`default_nettype wire
